>>> sv/grdc_pkg.sv
// shared constants and types of the grid ray door caster
package grdc_pkg;

    localparam int MAP_SIDE      = 64;
    localparam int CELL_W        = 6;
    localparam int FRAC_BITS     = 16;
    localparam int SCREEN_HEIGHT = 512;
    localparam int WALK_LIMIT    = 2 * (64 + MAP_SIDE + 2);
    localparam int DIV_W         = 38;

    localparam logic [31:0]      DIST_MAX     = 32'hFFFF_FFFF;
    localparam logic [12:0]      STRIP_MAX    = 13'd5120;
    localparam logic [DIV_W-1:0] DIV_DELTA    = 38'h00_4000_0000;
    localparam logic [DIV_W-1:0] DIV_STRIP    = 38'h00_0200_0000;

    // register indexes
    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;
    localparam logic [2:0] REG_GRID_W  = 3'd6;
    localparam logic [2:0] REG_GRID_H  = 3'd7;

    localparam logic       CMD_CAST  = 1'b0;
    localparam logic       CMD_WRITE = 1'b1;
    localparam logic       HIT_DOOR  = 1'b0;
    localparam logic       HIT_OUT   = 1'b1;
    localparam logic [1:0] FACE_X    = 2'd0;
    localparam logic [1:0] FACE_Y    = 2'd1;
    localparam logic [1:0] FACE_OUT  = 2'd2;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [31:0]      divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic                rd;
        logic                wr;
        logic [CELL_W-1:0]   row;
        logic [MAP_SIDE-1:0] wdata;
    } t_mem_req;

endpackage

>>> sv/grdc_if.sv
// channel interfaces for commands and cast results
interface grdc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [9:0] column;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       door_bit;

    modport source (output valid, command, column, cell_x, cell_y, door_bit, input ready);
    modport sink   (input valid, command, column, cell_x, cell_y, door_bit, output ready);
endinterface

interface grdc_out_if;
    logic               valid;
    logic               ready;
    logic               hit_kind;
    logic [1:0]         face;
    logic signed [7:0]  hit_x;
    logic signed [7:0]  hit_y;
    logic [31:0]        perp_dist;
    logic [12:0]        strip_height;
    logic [8:0]         strip_top;
    logic [8:0]         strip_bottom;

    modport source (output valid, hit_kind, face, hit_x, hit_y, perp_dist, strip_height,
                    strip_top, strip_bottom, input ready);
    modport sink   (input valid, hit_kind, face, hit_x, hit_y, perp_dist, strip_height,
                    strip_top, strip_bottom, output ready);
endinterface

>>> sv/grid_ray_door_caster_core.sv
// grid ray caster with door map: camera maths, dda walk and strip bounds
// a door write reads the door row, then writes it back; a cast uses up to four divisions on
// the shared bit-serial divider; one item at a time, no new item is taken until the last is
// through; the grid walk (read of the door row, then test) and the divider set how long a cast
// takes; a finished result waits in the output register
// reset: synchronous active low; configuration, state and output valid return to defaults;
// the door map is cleared one row a cycle, and no item is taken meanwhile
module grid_ray_door_caster_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    grdc_in_if.sink     i_in,
    grdc_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_WRB  = 5'd1;   // write back modified door row
    localparam logic [4:0] S_CAM  = 5'd2;   // plane times camera coordinate
    localparam logic [4:0] S_RAY  = 5'd3;   // ray direction, saturated
    localparam logic [4:0] S_DX   = 5'd4;
    localparam logic [4:0] S_WX   = 5'd5;
    localparam logic [4:0] S_DY   = 5'd6;
    localparam logic [4:0] S_WY   = 5'd7;
    localparam logic [4:0] S_SD1  = 5'd8;   // initial side distance products
    localparam logic [4:0] S_SD2  = 5'd9;
    localparam logic [4:0] S_WALK = 5'd10;  // one dda step, read of the new row
    localparam logic [4:0] S_CHK  = 5'd11;  // bounds and door test
    localparam logic [4:0] S_FD   = 5'd12;  // perpendicular distance
    localparam logic [4:0] S_WF   = 5'd13;
    localparam logic [4:0] S_SH   = 5'd14;  // strip height
    localparam logic [4:0] S_WS   = 5'd15;
    localparam logic [4:0] S_FIN  = 5'd16;  // strip bounds, hand over to output register

    // configuration registers
    logic [21:0]        r_pos_x, r_pos_y;
    logic signed [15:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [6:0]         r_gw, r_gh;

    logic [4:0]         r_state;
    logic [9:0]         r_col;
    logic signed [7:0]  r_mx, r_my;
    logic               r_bit;
    logic signed [31:0] r_cprod_x, r_cprod_y;
    logic signed [15:0] r_rdx, r_rdy;
    logic [31:0]        r_ddx, r_ddy;
    logic signed [57:0] r_sprod_x, r_sprod_y;
    logic signed [43:0] r_sdx, r_sdy;
    logic               r_side;
    logic [8:0]         r_n;
    logic               r_kind;
    logic [1:0]         r_face;
    logic [31:0]        r_perp;
    logic [12:0]        r_lh;

    // output register
    logic               r_ov;
    logic               r_o_kind;
    logic [1:0]         r_o_face;
    logic signed [7:0]  r_o_x, r_o_y;
    logic [31:0]        r_o_perp;
    logic [12:0]        r_o_lh;
    logic [8:0]         r_o_top, r_o_bot;

    grdc_pkg::t_div_req div_req;
    grdc_pkg::t_div_rsp div_rsp;
    grdc_pkg::t_mem_req mem_req;
    logic [grdc_pkg::MAP_SIDE-1:0] mem_rdata;
    logic               mem_busy;

    grdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    grdc_door_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    // apb register file
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_dir_x   <= 16'sd16384;
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= 16'sd10813;
            r_gw      <= 7'd64;
            r_gh      <= 7'd64;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                grdc_pkg::REG_POS_X:   r_pos_x   <= pwdata[21:0];
                grdc_pkg::REG_POS_Y:   r_pos_y   <= pwdata[21:0];
                grdc_pkg::REG_DIR_X:   r_dir_x   <= pwdata[15:0];
                grdc_pkg::REG_DIR_Y:   r_dir_y   <= pwdata[15:0];
                grdc_pkg::REG_PLANE_X: r_plane_x <= pwdata[15:0];
                grdc_pkg::REG_PLANE_Y: r_plane_y <= pwdata[15:0];
                grdc_pkg::REG_GRID_W:  r_gw      <= pwdata[6:0];
                grdc_pkg::REG_GRID_H:  r_gh      <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            grdc_pkg::REG_POS_X:   prdata = {10'b0, r_pos_x};
            grdc_pkg::REG_POS_Y:   prdata = {10'b0, r_pos_y};
            grdc_pkg::REG_DIR_X:   prdata = {{16{r_dir_x[15]}}, r_dir_x};
            grdc_pkg::REG_DIR_Y:   prdata = {{16{r_dir_y[15]}}, r_dir_y};
            grdc_pkg::REG_PLANE_X: prdata = {{16{r_plane_x[15]}}, r_plane_x};
            grdc_pkg::REG_PLANE_Y: prdata = {{16{r_plane_y[15]}}, r_plane_y};
            grdc_pkg::REG_GRID_W:  prdata = {25'b0, r_gw};
            grdc_pkg::REG_GRID_H:  prdata = {25'b0, r_gh};
            default:               prdata = '0;
        endcase
    end

    // input transfer
    logic in_xfer;
    assign i_in.ready = (r_state == S_IDLE) && !mem_busy;
    assign in_xfer    = i_in.valid && i_in.ready;

    // camera coordinate: 2*column*2^14/width - 2^14, width of 1024 columns
    logic signed [15:0] cam;
    assign cam = $signed({1'b0, r_col, 5'b0}) - 16'sd16384;

    // ray direction with saturation to 16 bits
    logic signed [18:0] sum_x, sum_y;
    logic signed [15:0] sat_x, sat_y;
    assign sum_x = 19'(r_dir_x) + 19'(r_cprod_x >>> 14);
    assign sum_y = 19'(r_dir_y) + 19'(r_cprod_y >>> 14);
    always_comb begin
        if (sum_x > 19'sd32767)       sat_x = 16'sh7FFF;
        else if (sum_x < -19'sd32768) sat_x = 16'sh8000;
        else                          sat_x = sum_x[15:0];
        if (sum_y > 19'sd32767)       sat_y = 16'sh7FFF;
        else if (sum_y < -19'sd32768) sat_y = 16'sh8000;
        else                          sat_y = sum_y[15:0];
    end

    logic [15:0] mag_x, mag_y;
    assign mag_x = r_rdx[15] ? 16'(-r_rdx) : r_rdx;
    assign mag_y = r_rdy[15] ? 16'(-r_rdy) : r_rdy;

    // player position and cell borders, 25-bit signed fixed point
    logic signed [24:0] px, py, bx, by, sd0_x, sd0_y;
    logic signed [7:0]  cx, cy;
    assign px    = $signed({3'b000, r_pos_x});
    assign py    = $signed({3'b000, r_pos_y});
    assign cx    = r_rdx[15] ? r_mx : r_mx + 8'sd1;
    assign cy    = r_rdy[15] ? r_my : r_my + 8'sd1;
    assign bx    = $signed({cx[7], cx, 16'b0});
    assign by    = $signed({cy[7], cy, 16'b0});
    assign sd0_x = r_rdx[15] ? px - bx : bx - px;
    assign sd0_y = r_rdy[15] ? py - by : by - py;

    logic signed [57:0] sh_x, sh_y;
    assign sh_x = r_sprod_x >>> grdc_pkg::FRAC_BITS;
    assign sh_y = r_sprod_y >>> grdc_pkg::FRAC_BITS;

    // one dda step
    logic              take_x;
    logic signed [7:0] step_mx, step_my;
    assign take_x  = r_sdx < r_sdy;
    assign step_mx = r_rdx[15] ? r_mx - 8'sd1 : r_mx + 8'sd1;
    assign step_my = r_rdy[15] ? r_my - 8'sd1 : r_my + 8'sd1;

    // bounds, sizes above the map side count as the map side
    logic [6:0] gw_eff, gh_eff;
    logic       outside, door;
    assign gw_eff  = (r_gw > 7'(grdc_pkg::MAP_SIDE)) ? 7'(grdc_pkg::MAP_SIDE) : r_gw;
    assign gh_eff  = (r_gh > 7'(grdc_pkg::MAP_SIDE)) ? 7'(grdc_pkg::MAP_SIDE) : r_gh;
    assign outside = r_mx[7] || r_my[7] || (r_mx[6:0] >= gw_eff) || (r_my[6:0] >= gh_eff);
    assign door    = mem_rdata[r_mx[5:0]];

    // distance to the face crossed last; the border lies on the far side for a negative step
    logic signed [7:0]  fx, fy;
    logic signed [24:0] fbx, fby;
    logic signed [24:0] num, num_mag;
    logic signed [15:0] rd_f;
    logic [15:0]        rd_fmag;
    assign fx      = r_rdx[15] ? r_mx + 8'sd1 : r_mx;
    assign fy      = r_rdy[15] ? r_my + 8'sd1 : r_my;
    assign fbx     = $signed({fx[7], fx, 16'b0});
    assign fby     = $signed({fy[7], fy, 16'b0});
    assign num     = r_side ? fby - py : fbx - px;
    assign rd_f    = r_side ? r_rdy : r_rdx;
    assign rd_fmag = r_side ? mag_y : mag_x;
    assign num_mag = num[24] ? -num : num;

    logic [11:0] half;
    logic [12:0] bot_sum;
    assign half    = r_lh[12:1];
    assign bot_sum = {1'b0, half} + 13'(grdc_pkg::SCREEN_HEIGHT / 2);

    logic out_free;
    assign out_free = !r_ov || o_out.ready;

    // requests to the divider and the door memory
    always_comb begin
        div_req = '0;
        unique case (r_state)
            S_DX: begin
                div_req.start    = r_rdx != 16'sd0;
                div_req.dividend = grdc_pkg::DIV_DELTA;
                div_req.divisor  = {16'b0, mag_x};
            end
            S_DY: begin
                div_req.start    = r_rdy != 16'sd0;
                div_req.dividend = grdc_pkg::DIV_DELTA;
                div_req.divisor  = {16'b0, mag_y};
            end
            S_FD: begin
                div_req.start    = (rd_f != 16'sd0) && !((num != 25'sd0) && (num[24] != rd_f[15]));
                div_req.dividend = {num_mag[23:0], 14'b0};
                div_req.divisor  = {16'b0, rd_fmag};
            end
            S_SH: begin
                div_req.start    = r_perp != 32'd0;
                div_req.dividend = grdc_pkg::DIV_STRIP;
                div_req.divisor  = r_perp;
            end
            default: ;
        endcase
    end

    always_comb begin
        mem_req       = '0;
        mem_req.wdata = mem_rdata;
        unique case (r_state)
            S_IDLE: begin
                mem_req.rd  = in_xfer && (i_in.command == grdc_pkg::CMD_WRITE);
                mem_req.row = i_in.cell_y;
            end
            S_WRB: begin
                mem_req.wr              = 1'b1;
                mem_req.row             = r_my[5:0];
                mem_req.wdata[r_mx[5:0]] = r_bit;
            end
            S_WALK: begin
                mem_req.rd  = 1'b1;
                mem_req.row = take_x ? r_my[5:0] : step_my[5:0];
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (in_xfer)
                    r_state <= (i_in.command == grdc_pkg::CMD_WRITE) ? S_WRB : S_CAM;
                S_WRB:  r_state <= S_IDLE;
                S_CAM:  r_state <= S_RAY;
                S_RAY:  r_state <= S_DX;
                S_DX:   r_state <= div_req.start ? S_WX : S_DY;
                S_WX:   if (div_rsp.done) r_state <= S_DY;
                S_DY:   r_state <= div_req.start ? S_WY : S_SD1;
                S_WY:   if (div_rsp.done) r_state <= S_SD1;
                S_SD1:  r_state <= S_SD2;
                S_SD2:  r_state <= S_WALK;
                S_WALK: r_state <= S_CHK;
                S_CHK: begin
                    if (outside) r_state <= S_SH;
                    else if (door) r_state <= S_FD;
                    else if (r_n == 9'(grdc_pkg::WALK_LIMIT - 1)) r_state <= S_SH;
                    else r_state <= S_WALK;
                end
                S_FD:   r_state <= div_req.start ? S_WF : S_SH;
                S_WF:   if (div_rsp.done) r_state <= S_SH;
                S_SH:   r_state <= div_req.start ? S_WS : S_FIN;
                S_WS:   if (div_rsp.done) r_state <= S_FIN;
                S_FIN:  if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (in_xfer) begin
                r_col  <= i_in.column;
                r_mx   <= $signed({2'b00, i_in.cell_x});
                r_my   <= $signed({2'b00, i_in.cell_y});
                r_bit  <= i_in.door_bit;
                r_n    <= '0;
                r_kind <= grdc_pkg::HIT_OUT;
                r_face <= grdc_pkg::FACE_OUT;
                r_perp <= grdc_pkg::DIST_MAX;
            end
            S_CAM: begin
                r_cprod_x <= r_plane_x * cam;
                r_cprod_y <= r_plane_y * cam;
            end
            S_RAY: begin
                r_rdx <= sat_x;
                r_rdy <= sat_y;
            end
            S_DX: if (!div_req.start) r_ddx <= grdc_pkg::DIST_MAX;
            S_WX: if (div_rsp.done) r_ddx <= div_rsp.quot[31:0];
            S_DY: if (!div_req.start) r_ddy <= grdc_pkg::DIST_MAX;
            S_WY: if (div_rsp.done) r_ddy <= div_rsp.quot[31:0];
            S_SD1: begin
                r_sprod_x <= 58'(sd0_x) * $signed({1'b0, r_ddx});
                r_sprod_y <= 58'(sd0_y) * $signed({1'b0, r_ddy});
            end
            S_SD2: begin
                r_sdx <= sh_x[43:0];
                r_sdy <= sh_y[43:0];
            end
            S_WALK: begin
                r_side <= !take_x;
                if (take_x) begin
                    r_sdx <= r_sdx + $signed({12'b0, r_ddx});
                    r_mx  <= step_mx;
                end else begin
                    r_sdy <= r_sdy + $signed({12'b0, r_ddy});
                    r_my  <= step_my;
                end
            end
            S_CHK: begin
                r_n <= r_n + 9'd1;
                if (!outside && door) begin
                    r_kind <= grdc_pkg::HIT_DOOR;
                    r_face <= r_side ? grdc_pkg::FACE_Y : grdc_pkg::FACE_X;
                end
            end
            S_FD: if (!div_req.start)
                r_perp <= (rd_f == 16'sd0) ? grdc_pkg::DIST_MAX : 32'd0;
            S_WF: if (div_rsp.done)
                r_perp <= (div_rsp.quot[37:32] != 6'd0) ? grdc_pkg::DIST_MAX
                                                         : div_rsp.quot[31:0];
            S_SH: if (!div_req.start) r_lh <= grdc_pkg::STRIP_MAX;
            S_WS: if (div_rsp.done)
                r_lh <= (div_rsp.quot > 38'(grdc_pkg::STRIP_MAX)) ? grdc_pkg::STRIP_MAX
                                                                 : div_rsp.quot[12:0];
            default: ;
        endcase
    end

    // output register, loaded once the previous result has gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_o_kind <= r_kind;
            r_o_face <= r_face;
            r_o_x    <= r_mx;
            r_o_y    <= r_my;
            r_o_perp <= r_perp;
            r_o_lh   <= r_lh;
            r_o_top  <= (half >= 12'(grdc_pkg::SCREEN_HEIGHT / 2)) ? 9'd0
                        : 9'(12'(grdc_pkg::SCREEN_HEIGHT / 2) - half);
            r_o_bot  <= (bot_sum >= 13'(grdc_pkg::SCREEN_HEIGHT))
                        ? 9'(grdc_pkg::SCREEN_HEIGHT - 1) : bot_sum[8:0];
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.hit_kind     = r_o_kind;
    assign o_out.face         = r_o_face;
    assign o_out.hit_x        = r_o_x;
    assign o_out.hit_y        = r_o_y;
    assign o_out.perp_dist    = r_o_perp;
    assign o_out.strip_height = r_o_lh;
    assign o_out.strip_top    = r_o_top;
    assign o_out.strip_bottom = r_o_bot;

`ifndef ASSERT_OFF
    // a result of kind out (ray left the map or walk ended) reports the out face and the maximum distance
    a_left_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_kind == grdc_pkg::HIT_OUT)
            |-> (r_o_face == grdc_pkg::FACE_OUT && r_o_perp == grdc_pkg::DIST_MAX))
        else $error("left-map result with wrong face or distance");

    // strip bounds stay ordered
    a_strip_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o_top <= r_o_bot))
        else $error("strip top below strip bottom");

    // no divider start while it is still iterating
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // no transfer is taken during the clearing pass
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_busy |-> !i_in.ready)
        else $error("input ready during door map clear");
`endif
endmodule

>>> sv/grdc_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module grdc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  grdc_pkg::t_div_req  i_req,
    output grdc_pkg::t_div_rsp  o_rsp
);
    localparam int W = grdc_pkg::DIV_W;

    logic         r_busy;
    logic         r_done;
    logic [5:0]   r_cnt;
    logic [31:0]  r_rem;
    logic [31:0]  r_div;
    logic [W-1:0] r_quo;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {r_rem, r_quo[W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[31:0] : trial[31:0];
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
endmodule

>>> sv/grdc_door_mem.sv
// door map memory, one row of cells per word, cleared row by row after reset
module grdc_door_mem (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  grdc_pkg::t_mem_req                 i_req,
    output logic [grdc_pkg::MAP_SIDE-1:0]      o_rdata,
    output logic                               o_busy
);
    localparam int RW = grdc_pkg::CELL_W;
    localparam int DW = grdc_pkg::MAP_SIDE;

    logic [DW-1:0] mem [0:DW-1];
    logic          r_clr;
    logic [RW-1:0] r_clr_row;
    logic [DW-1:0] r_rdata;

    logic          we;
    logic [RW-1:0] waddr;
    logic [DW-1:0] wdata;

    assign we    = r_clr || i_req.wr;
    assign waddr = r_clr ? r_clr_row : i_req.row;
    assign wdata = r_clr ? '0 : i_req.wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_row <= '0;
        end else if (r_clr) begin
            r_clr_row <= r_clr_row + 1'b1;
            if (r_clr_row == RW'(DW - 1)) r_clr <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (i_req.rd) r_rdata <= mem[i_req.row];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr;
endmodule

>>> tb/grdc_tb_if.sv
`timescale 1ns / 100ps
// note: the channel interfaces come from sv/grdc_if.sv; this file holds only the cast result type
package grdc_tb_types;
    typedef struct packed {
        logic              hit_kind;
        logic [1:0]        face;
        logic signed [7:0] hit_x;
        logic signed [7:0] hit_y;
        logic [31:0]       perp_dist;
        logic [12:0]       strip_height;
        logic [8:0]        strip_top;
        logic [8:0]        strip_bottom;
    } t_cast_result;
endpackage

>>> tb/grdc_checker.sv
`timescale 1ns / 100ps
// cast predictor and result checker
module grdc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    grdc_in_if          in_ch,
    grdc_out_if         out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    logic               doors [grdc_pkg::MAP_SIDE*grdc_pkg::MAP_SIDE];
    logic [21:0]        cfg_pos_x, cfg_pos_y;
    logic signed [15:0] cfg_dir_x, cfg_dir_y, cfg_plane_x, cfg_plane_y;
    logic [6:0]         cfg_grid_w, cfg_grid_h;
    grdc_tb_types::t_cast_result expected_casts [$];

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat_dir(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint face_distance(longint num, longint rd);
        longint q;
        if (rd == 0) return longint'(grdc_pkg::DIST_MAX);
        if (num != 0 && ((num < 0) != (rd < 0))) return 0;
        q = (abs64(num) << (30 - grdc_pkg::FRAC_BITS)) / abs64(rd);
        return q > longint'(grdc_pkg::DIST_MAX) ? longint'(grdc_pkg::DIST_MAX) : q;
    endfunction

    function automatic grdc_tb_types::t_cast_result cast_ray(logic [9:0] col, logic [5:0] cx,
                                                             logic [5:0] cy);
        grdc_tb_types::t_cast_result r;
        longint cam, rdx, rdy, ddx, ddy, sdx, sdy, mx, my, gw, gh, perp, lh, top, bot;
        longint stx, sty;
        int side, kind, fc;
        cam = ((longint'(col) << 15) / 1024) - 16384;
        rdx = sat_dir(longint'(cfg_dir_x) + floor_shift(longint'(cfg_plane_x) * cam, 14));
        rdy = sat_dir(longint'(cfg_dir_y) + floor_shift(longint'(cfg_plane_y) * cam, 14));
        ddx = rdx == 0 ? longint'(grdc_pkg::DIST_MAX) : (64'd1 << 30) / abs64(rdx);
        ddy = rdy == 0 ? longint'(grdc_pkg::DIST_MAX) : (64'd1 << 30) / abs64(rdy);
        mx = cx;
        my = cy;
        if (rdx < 0) begin
            stx = -1; sdx = longint'(cfg_pos_x) - (mx << grdc_pkg::FRAC_BITS);
        end else begin
            stx = 1; sdx = ((mx + 1) << grdc_pkg::FRAC_BITS) - longint'(cfg_pos_x);
        end
        if (rdy < 0) begin
            sty = -1; sdy = longint'(cfg_pos_y) - (my << grdc_pkg::FRAC_BITS);
        end else begin
            sty = 1; sdy = ((my + 1) << grdc_pkg::FRAC_BITS) - longint'(cfg_pos_y);
        end
        sdx = floor_shift(sdx * ddx, grdc_pkg::FRAC_BITS);
        sdy = floor_shift(sdy * ddy, grdc_pkg::FRAC_BITS);
        gw = cfg_grid_w > grdc_pkg::MAP_SIDE ? grdc_pkg::MAP_SIDE : cfg_grid_w;
        gh = cfg_grid_h > grdc_pkg::MAP_SIDE ? grdc_pkg::MAP_SIDE : cfg_grid_h;
        perp = longint'(grdc_pkg::DIST_MAX);
        kind = grdc_pkg::HIT_OUT;
        fc = grdc_pkg::FACE_OUT;
        for (int n = 0; n < grdc_pkg::WALK_LIMIT; n++) begin
            if (sdx < sdy) begin
                sdx += ddx; mx += stx; side = 0;
            end else begin
                sdy += ddy; my += sty; side = 1;
            end
            if (mx < 0 || mx >= gw || my < 0 || my >= gh) break;
            if (doors[my*grdc_pkg::MAP_SIDE + mx]) begin
                kind = grdc_pkg::HIT_DOOR;
                fc = side;
                if (side == 0)
                    perp = face_distance(((mx + (stx < 0 ? 1 : 0)) << grdc_pkg::FRAC_BITS)
                                         - longint'(cfg_pos_x), rdx);
                else
                    perp = face_distance(((my + (sty < 0 ? 1 : 0)) << grdc_pkg::FRAC_BITS)
                                         - longint'(cfg_pos_y), rdy);
                break;
            end
        end
        if (perp == 0) lh = grdc_pkg::STRIP_MAX;
        else begin
            lh = (longint'(grdc_pkg::SCREEN_HEIGHT) << 16) / perp;
            if (lh > grdc_pkg::STRIP_MAX) lh = grdc_pkg::STRIP_MAX;
        end
        top = (lh / 2 >= grdc_pkg::SCREEN_HEIGHT / 2) ? 0
              : grdc_pkg::SCREEN_HEIGHT / 2 - lh / 2;
        bot = lh / 2 + grdc_pkg::SCREEN_HEIGHT / 2;
        if (bot >= grdc_pkg::SCREEN_HEIGHT) bot = grdc_pkg::SCREEN_HEIGHT - 1;
        r.hit_kind = kind[0];
        r.face = fc[1:0];
        r.hit_x = mx[7:0];
        r.hit_y = my[7:0];
        r.perp_dist = perp[31:0];
        r.strip_height = lh[12:0];
        r.strip_top = top[8:0];
        r.strip_bottom = bot[8:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        grdc_tb_types::t_cast_result exp_r;
        if (!i_rst_n) begin
            foreach (doors[k]) doors[k] = 1'b0;
            cfg_pos_x = '0; cfg_pos_y = '0;
            cfg_dir_x = 16384; cfg_dir_y = 0;
            cfg_plane_x = 0; cfg_plane_y = 10813;
            cfg_grid_w = 64; cfg_grid_h = 64;
            o_fail_count = 0;
            expected_casts.delete();
        end else begin
            // register write lands on the access cycle
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    grdc_pkg::REG_POS_X:   cfg_pos_x = pwdata[21:0];
                    grdc_pkg::REG_POS_Y:   cfg_pos_y = pwdata[21:0];
                    grdc_pkg::REG_DIR_X:   cfg_dir_x = pwdata[15:0];
                    grdc_pkg::REG_DIR_Y:   cfg_dir_y = pwdata[15:0];
                    grdc_pkg::REG_PLANE_X: cfg_plane_x = pwdata[15:0];
                    grdc_pkg::REG_PLANE_Y: cfg_plane_y = pwdata[15:0];
                    grdc_pkg::REG_GRID_W:  cfg_grid_w = pwdata[6:0];
                    grdc_pkg::REG_GRID_H:  cfg_grid_h = pwdata[6:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_casts.size() == 0) begin
                    $error("unexpected result transfer");
                    o_fail_count++;
                end else begin
                    exp_r = expected_casts.pop_front();
                    if (out_ch.hit_kind !== exp_r.hit_kind) begin
                        $error("hit_kind exp %0d got %0d", exp_r.hit_kind, out_ch.hit_kind);
                        o_fail_count++;
                    end
                    if (out_ch.face !== exp_r.face) begin
                        $error("face exp %0d got %0d", exp_r.face, out_ch.face);
                        o_fail_count++;
                    end
                    if (out_ch.hit_x !== exp_r.hit_x) begin
                        $error("hit_x exp %0d got %0d", exp_r.hit_x, out_ch.hit_x);
                        o_fail_count++;
                    end
                    if (out_ch.hit_y !== exp_r.hit_y) begin
                        $error("hit_y exp %0d got %0d", exp_r.hit_y, out_ch.hit_y);
                        o_fail_count++;
                    end
                    if (out_ch.perp_dist !== exp_r.perp_dist) begin
                        $error("perp_dist exp %h got %h", exp_r.perp_dist, out_ch.perp_dist);
                        o_fail_count++;
                    end
                    if (out_ch.strip_height !== exp_r.strip_height) begin
                        $error("strip_height exp %0d got %0d", exp_r.strip_height,
                               out_ch.strip_height);
                        o_fail_count++;
                    end
                    if (out_ch.strip_top !== exp_r.strip_top) begin
                        $error("strip_top exp %0d got %0d", exp_r.strip_top, out_ch.strip_top);
                        o_fail_count++;
                    end
                    if (out_ch.strip_bottom !== exp_r.strip_bottom) begin
                        $error("strip_bottom exp %0d got %0d", exp_r.strip_bottom,
                               out_ch.strip_bottom);
                        o_fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.command == grdc_pkg::CMD_WRITE)
                    doors[in_ch.cell_y*grdc_pkg::MAP_SIDE + in_ch.cell_x] = in_ch.door_bit;
                else
                    expected_casts.push_back(cast_ray(in_ch.column, in_ch.cell_x, in_ch.cell_y));
            end
        end
        o_pending = expected_casts.size();
    end
endmodule

>>> tb/grid_ray_door_caster_core_test.sv
`timescale 1ns / 100ps
// stimulus and verdict for the grid ray door caster
module grid_ray_door_caster_core_test;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          stall_pct = 15;   // idling chance, percent
    bit          hold_off = 1'b0;  // long receiver stall
    int          idle_cycles = 0;

    grdc_in_if  cmd_ch ();
    grdc_out_if res_ch ();

    grid_ray_door_caster_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(cmd_ch.sink), .o_out(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    grdc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(cmd_ch), .out_ch(res_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: random stalls, or a held-off stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("grid_ray_door_caster_core: mismatch");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // one command transfer, with random gaps first
    task automatic send_cmd(logic cmd, logic [9:0] col, logic [5:0] cx, logic [5:0] cy,
                            logic db);
        while ($urandom_range(99) < stall_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1; cmd_ch.command <= cmd; cmd_ch.column <= col;
        cmd_ch.cell_x <= cx; cmd_ch.cell_y <= cy; cmd_ch.door_bit <= db;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic rand_cast(int gw, int gh);
        send_cmd(grdc_pkg::CMD_CAST, $urandom_range(1023), $urandom_range(gw - 1),
                 $urandom_range(gh - 1), $urandom_range(1));
    endtask

    task automatic rand_setup();
        int gw, gh;
        gw = $urandom_range(2, 16);
        gh = $urandom_range(2, 16);
        reg_write(grdc_pkg::REG_GRID_W, gw);
        reg_write(grdc_pkg::REG_GRID_H, gh);
        // player mostly inside the start region, sometimes anywhere
        reg_write(grdc_pkg::REG_POS_X, $urandom_range(4) == 0 ? $urandom_range(22'h3FFFFF)
                                                              : $urandom_range(gw * 65536 - 1));
        reg_write(grdc_pkg::REG_POS_Y, $urandom_range(4) == 0 ? $urandom_range(22'h3FFFFF)
                                                              : $urandom_range(gh * 65536 - 1));
        reg_write(grdc_pkg::REG_DIR_X, $urandom_range(3) == 0 ? 0 : $urandom_range(16'hFFFF));
        reg_write(grdc_pkg::REG_DIR_Y, $urandom_range(3) == 0 ? 0 : $urandom_range(16'hFFFF));
        reg_write(grdc_pkg::REG_PLANE_X, $urandom_range(16'hFFFF));
        reg_write(grdc_pkg::REG_PLANE_Y, $urandom_range(16'hFFFF));
    endtask

    initial begin
        cmd_ch.valid <= 1'b0; cmd_ch.command <= grdc_pkg::CMD_CAST; cmd_ch.column <= '0;
        cmd_ch.cell_x <= '0; cmd_ch.cell_y <= '0; cmd_ch.door_bit <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // default registers, empty map: the ray leaves the map
        send_cmd(grdc_pkg::CMD_CAST, 0, 0, 0, 0);
        send_cmd(grdc_pkg::CMD_CAST, 1023, 63, 63, 0);
        send_cmd(grdc_pkg::CMD_CAST, 512, 5, 5, 0);
        // doors beside cell (5,5) and at the far corner, then casts from near them
        send_cmd(grdc_pkg::CMD_WRITE, 0, 10, 5, 1);
        send_cmd(grdc_pkg::CMD_WRITE, 0, 5, 10, 1);
        send_cmd(grdc_pkg::CMD_WRITE, 1023, 63, 63, 1);
        send_cmd(grdc_pkg::CMD_CAST, 512, 5, 5, 0);
        send_cmd(grdc_pkg::CMD_CAST, 1023, 62, 62, 1);
        // start cell not holding the player
        send_cmd(grdc_pkg::CMD_CAST, 512, 9, 5, 0);
        send_cmd(grdc_pkg::CMD_WRITE, 0, 10, 5, 0);
        drain();
        // zero x direction and planes, extreme position, oversized and zero grid
        reg_write(grdc_pkg::REG_POS_X, 22'h3FFFFF);
        reg_write(grdc_pkg::REG_POS_Y, 22'h3FFFFF);
        reg_write(grdc_pkg::REG_DIR_X, 0);
        reg_write(grdc_pkg::REG_DIR_Y, 32'hFFFF8000);
        reg_write(grdc_pkg::REG_PLANE_X, 0);
        reg_write(grdc_pkg::REG_PLANE_Y, 0);
        reg_write(grdc_pkg::REG_GRID_W, 127);
        reg_write(grdc_pkg::REG_GRID_H, 0);
        send_cmd(grdc_pkg::CMD_CAST, 512, 0, 0, 0);
        send_cmd(grdc_pkg::CMD_CAST, 700, 63, 63, 0);
        drain();
        reg_write(grdc_pkg::REG_GRID_H, 64);
        reg_write(grdc_pkg::REG_POS_X, 5 << 16);
        reg_write(grdc_pkg::REG_POS_Y, 32'h0007_FFFF);
        reg_write(grdc_pkg::REG_DIR_X, 32'h7FFF);
        reg_write(grdc_pkg::REG_PLANE_X, 32'h7FFF);
        reg_write(grdc_pkg::REG_PLANE_Y, 32'h7FFF);
        send_cmd(grdc_pkg::CMD_WRITE, 0, 5, 6, 1);
        send_cmd(grdc_pkg::CMD_CAST, 1023, 5, 7, 0);
        send_cmd(grdc_pkg::CMD_CAST, 0, 5, 7, 0);
        send_cmd(grdc_pkg::CMD_CAST, 256, 5, 2, 0);
        drain();

        // random phases: few items each, small grids so walks are short
        for (int ph = 0; ph < 40; ph++) begin
            int gw_cur, gh_cur;
            stall_pct = (ph >= 10 && ph < 14) ? 0 : 15;
            rand_setup();
            gw_cur = 16; gh_cur = 16;
            for (int k = 0; k < 30; k++) begin
                if ($urandom_range(2) == 0)
                    send_cmd(grdc_pkg::CMD_WRITE, $urandom_range(1023), $urandom_range(15),
                             $urandom_range(15), $urandom_range(3) != 0);
                else
                    rand_cast(gw_cur, gh_cur);
                if (ph == 5 && k == 3) begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (3000) @(posedge i_clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
            end
            drain();
        end
        if (fail_count == 0)
            $display("grid_ray_door_caster_core: match");
        else
            $display("grid_ray_door_caster_core: mismatch");
        $finish;
    end
endmodule

>>> grid_ray_door_caster_core.f
sv/grdc_pkg.sv
sv/grdc_if.sv
sv/grdc_div.sv
sv/grdc_door_mem.sv
sv/grid_ray_door_caster_core.sv
tb/grdc_tb_if.sv
tb/grdc_checker.sv
tb/grid_ray_door_caster_core_test.sv
